// File: sv/int_to_ascii_radix_unit_assert.svh
// assertion macros for the integer to ascii converter
// used by the port checker; needs clk and rst_n in scope
`ifndef INT_TO_ASCII_RADIX_UNIT_ASSERT_SVH
`define INT_TO_ASCII_RADIX_UNIT_ASSERT_SVH

// same-cycle implication
`define ITA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("int_to_ascii_radix_unit: check failed");

// next-cycle implication
`define ITA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("int_to_ascii_radix_unit: check failed");

`endif

// File: sv/ita_pkg.sv
// shared types, constants and the digit to character mapping
// for the integer to ascii converter; no dependencies
package ita_pkg;

  localparam int VALUE_W = 32;
  localparam int DIGIT_W = 5;
  localparam int IDX_W   = 5;
  localparam int RADIX_W = 6;
  localparam int CHAR_W  = 8;
  localparam int BIT_CNT_W = $clog2(VALUE_W);

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd32;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;

  localparam logic [CHAR_W-1:0] ASCII_ZERO     = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_LETTER_A = 8'd65;
  localparam logic [CHAR_W-1:0] ASCII_MINUS    = 8'd45;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic div_step;
    logic dig_store;
    logic load_sign;
    logic load_digit;
  } ita_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic bit_last;
    logic quot_zero;
    logic neg;
    logic out_free;
    logic idx_zero;
  } ita_stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dw;
    dw = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d >= DIGIT_W'(10)) begin
      return ASCII_LETTER_A + dw - 8'd10;
    end
    return ASCII_ZERO + dw;
  endfunction

endpackage

// File: sv/ita_ctrl.sv
// sequencing state machine for the integer to ascii converter
// depends on ita_pkg for command and status types
module ita_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  ita_pkg::ita_stat_t stat,
  output ita_pkg::ita_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_NEXT = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.bit_last) begin
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        // store remainder as next digit, keep dividing the quotient until it is zero
        cmd.dig_store = 1'b1;
        state_nxt = stat.quot_zero ? ST_SIGN : ST_DIV;
      end
      ST_SIGN: begin
        if (!stat.neg) begin
          state_nxt = ST_EMIT;
        end else if (stat.out_free) begin
          cmd.load_sign = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.load_digit = 1'b1;
          if (stat.idx_zero) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/ita_dp.sv
// datapath: radix register, bit-serial divider, digit store and output register
// depends on ita_pkg for widths, constants and command/status types
module ita_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [ita_pkg::RADIX_W-1:0]   cfg_wr_data,
  input  logic [ita_pkg::VALUE_W-1:0]   in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ita_pkg::CHAR_W-1:0]    out_tdata,
  output logic                          out_tlast,
  input  ita_pkg::ita_cmd_t             cmd,
  output ita_pkg::ita_stat_t            stat
);

  logic [ita_pkg::RADIX_W-1:0]   radix_r;
  logic [ita_pkg::VALUE_W-1:0]   quot_r;
  logic [ita_pkg::DIGIT_W-1:0]   prem_r;
  logic [ita_pkg::BIT_CNT_W-1:0] bit_cnt_r;
  logic [ita_pkg::IDX_W-1:0]     wr_idx_r;
  logic [ita_pkg::IDX_W-1:0]     rd_idx_r;
  logic                          neg_r;
  logic [ita_pkg::CHAR_W-1:0]    char_r;
  logic                          last_r;
  logic                          out_valid_r;
  logic [ita_pkg::DIGIT_W-1:0]   digit_mem [2**ita_pkg::IDX_W];

  logic [ita_pkg::RADIX_W-1:0]   trial;
  logic                          ge;
  logic [ita_pkg::RADIX_W-1:0]   diff;
  logic [ita_pkg::VALUE_W-1:0]   mag;

  // restoring division step: shift one dividend bit into the partial remainder
  assign trial = {prem_r, quot_r[ita_pkg::VALUE_W-1]};
  assign ge    = (trial >= radix_r);
  assign diff  = trial - radix_r;
  assign mag   = in_tdata[ita_pkg::VALUE_W-1] ? (ita_pkg::VALUE_W'(0) - in_tdata) : in_tdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= ita_pkg::RADIX_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_wr_data < ita_pkg::RADIX_MIN) begin
        radix_r <= ita_pkg::RADIX_MIN;
      end else if (cfg_wr_data > ita_pkg::RADIX_MAX) begin
        radix_r <= ita_pkg::RADIX_MAX;
      end else begin
        radix_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_cnt_r <= '0;
    end else if (cmd.load || cmd.dig_store) begin
      bit_cnt_r <= '0;
    end else if (cmd.div_step) begin
      bit_cnt_r <= bit_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quot_r   <= mag;
      prem_r   <= '0;
      wr_idx_r <= '0;
      neg_r    <= in_tdata[ita_pkg::VALUE_W-1] && (radix_r == ita_pkg::RADIX_DEC);
    end else if (cmd.div_step) begin
      prem_r <= ge ? diff[ita_pkg::DIGIT_W-1:0] : trial[ita_pkg::DIGIT_W-1:0];
      quot_r <= {quot_r[ita_pkg::VALUE_W-2:0], ge};
    end else if (cmd.dig_store) begin
      prem_r   <= '0;
      wr_idx_r <= wr_idx_r + 1'b1;
    end
  end

  // digits land least significant first, read back from the top index down
  always_ff @(posedge clk) begin
    if (cmd.dig_store) begin
      digit_mem[wr_idx_r] <= prem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dig_store) begin
      rd_idx_r <= wr_idx_r;
    end else if (cmd.load_digit) begin
      rd_idx_r <= rd_idx_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sign) begin
      char_r <= ita_pkg::ASCII_MINUS;
      last_r <= 1'b0;
    end else if (cmd.load_digit) begin
      char_r <= ita_pkg::digit_char(digit_mem[rd_idx_r]);
      last_r <= (rd_idx_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_sign || cmd.load_digit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = char_r;
  assign out_tlast  = last_r;

  assign stat.bit_last  = (bit_cnt_r == ita_pkg::BIT_CNT_W'(ita_pkg::VALUE_W - 1));
  assign stat.quot_zero = (quot_r == '0);
  assign stat.neg       = neg_r;
  assign stat.out_free  = !out_valid_r || out_tready;
  assign stat.idx_zero  = (rd_idx_r == '0);

endmodule

// File: sv/int_to_ascii_radix_unit.sv
// top level of the integer to ascii converter
// depends on ita_pkg, ita_ctrl and ita_dp
//
// Converts one signed 32-bit word to text in the radix held in the radix register
// (2..32, reset 10, writes saturate), most significant character first, tlast on
// the final one; '-' leads only for negatives in radix 10, other radices print the
// magnitude. Each digit takes one pass of the one-bit restoring divider, one step per
// dividend bit, then a store step. A sign step follows, which also loads the minus when
// there is one, and the digits then leave one per cycle through the output register
// while the receiver is ready; a stalled receiver holds them there. A new word is taken
// only once the last character of the previous one is loaded into the output register;
// that character may still be waiting there when the next word goes in.
module int_to_ascii_radix_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [ita_pkg::RADIX_W-1:0] cfg_wr_data,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [ita_pkg::VALUE_W-1:0] in_tdata,   // [31:0] value
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [ita_pkg::CHAR_W-1:0]  out_tdata,  // [7:0] char_code
  output logic                        out_tlast
);

  ita_pkg::ita_cmd_t  cmd;
  ita_pkg::ita_stat_t stat;

  ita_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ita_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule

// File: sv/ita_checker.sv
// port-level checker for int_to_ascii_radix_unit, bound to the top level
// depends on ita_pkg and int_to_ascii_radix_unit_assert.svh
`include "int_to_ascii_radix_unit_assert.svh"

module ita_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [ita_pkg::CHAR_W-1:0] out_tdata,
  input logic                       out_tlast
);

  // a stalled word holds
  `ITA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // only minus, decimal digits or letters up to the radix 32 range
  `ITA_ASSERT_NOW(a_char_legal, out_tvalid, (out_tdata == ita_pkg::ASCII_MINUS) || ((out_tdata >= 8'd48) && (out_tdata <= 8'd57)) || ((out_tdata >= 8'd65) && (out_tdata <= 8'd86)))

  // a sign never ends the text
  `ITA_ASSERT_NOW(a_minus_not_last, out_tvalid && (out_tdata == ita_pkg::ASCII_MINUS), !out_tlast)

  // no new word while text of the current one is still pending
  `ITA_ASSERT_NOW(a_busy_mid_text, out_tvalid && !out_tlast, !in_tready)

  // a taken word makes the unit busy, dropping ready
  `ITA_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)

endmodule

bind int_to_ascii_radix_unit ita_checker u_ita_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
